>>> design/rtsf_pkg.sv
// ----------------------------------------------------------------------------
// Resistive touch sample filter package
// Shared widths, constants, register map and the types that travel between
// the configuration block, the front end, the command queue and the back end.
// ----------------------------------------------------------------------------
package rtsf_pkg;

  // Field widths.
  localparam int unsigned READING_W  = 12;
  localparam int unsigned VALUE_W    = 13;
  localparam int unsigned PRESSURE_W = 13;
  localparam int unsigned COORD_W    = 16;
  localparam int unsigned SUM_W      = 21;
  localparam int unsigned COUNT_W    = 5;
  localparam int unsigned REM_W      = 4;
  localparam int unsigned PROD_W     = VALUE_W + COORD_W;

  // ADC span and the edge window that rejects readings near the panel border.
  localparam logic [VALUE_W-1:0] ADC_SPAN  = 13'd4096;
  localparam logic [VALUE_W-1:0] EDGE_LOW  = 13'd50;
  localparam logic [VALUE_W-1:0] EDGE_HIGH = 13'd4046;

  // Defaults for the top-level parameters.
  localparam int unsigned SAMPLES_DEFAULT     = 8;
  localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

  // Configuration port geometry.
  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned APB_DATA_W = 32;

  // Register reset values.
  localparam logic [PRESSURE_W-1:0] THRESHOLD_RESET     = 13'd2000;
  localparam logic                  CONVERT_RESET       = 1'b0;
  localparam logic [COORD_W-1:0]    SCREEN_WIDTH_RESET  = 16'd320;
  localparam logic [COORD_W-1:0]    SCREEN_HEIGHT_RESET = 16'd240;

  // Register indexes (byte address is four times the index).
  typedef enum logic [1:0] {
    REG_THRESHOLD     = 2'd0,
    REG_CONVERT       = 2'd1,
    REG_SCREEN_WIDTH  = 2'd2,
    REG_SCREEN_HEIGHT = 2'd3
  } reg_idx_e;

  // Configuration seen by the back end.
  typedef struct packed {
    logic [PRESSURE_W-1:0] pressure_threshold;
    logic                  convert_enable;
    logic [COORD_W-1:0]    screen_width;
    logic [COORD_W-1:0]    screen_height;
  } cfg_t;

  // Classified command handed from the front end to the back end.
  typedef struct packed {
    logic                  is_position;
    logic                  in_window;
    logic [PRESSURE_W-1:0] pressure;
    logic [VALUE_W-1:0]    pos_x;
    logic [VALUE_W-1:0]    pos_y;
  } cmd_t;

endpackage

>>> design/rtsf_if.sv
// ----------------------------------------------------------------------------
// Resistive touch sample filter channels
// Request channel carrying ADC reading pairs and result channel carrying the
// filtered touch report, both with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface rtsf_req_if;
  logic                              valid;
  logic                              ready;
  logic                              req_type;
  logic [rtsf_pkg::READING_W-1:0]    first_reading;
  logic [rtsf_pkg::READING_W-1:0]    second_reading;

  modport source (
    output valid, req_type, first_reading, second_reading,
    input  ready
  );
  modport sink (
    input  valid, req_type, first_reading, second_reading,
    output ready
  );
endinterface

interface rtsf_rsp_if;
  logic                              valid;
  logic                              ready;
  logic                              touched;
  logic [rtsf_pkg::COORD_W-1:0]      pos_x;
  logic [rtsf_pkg::COORD_W-1:0]      pos_y;
  logic [rtsf_pkg::PRESSURE_W-1:0]   pressure;

  modport source (
    output valid, touched, pos_x, pos_y, pressure,
    input  ready
  );
  modport sink (
    input  valid, touched, pos_x, pos_y, pressure,
    output ready
  );
endinterface

>>> design/resistive_touch_sample_filter.sv
// ----------------------------------------------------------------------------
// Resistive touch sample filter
// Filters settled ADC reading pairs from a four-wire resistive panel into
// touch reports: pressure check, edge rejection, optional screen scaling and
// averaging over a configurable number of position samples.
// ----------------------------------------------------------------------------
// Flow: the front end takes one transaction per cycle into a small command
// queue while it has room. The back end handles a pressure pair in its fetch
// state (going on to the emit state when it reports no touch), a position
// pair through its fetch, scaling multiply and accumulate states, and on the
// last pair of a measurement with enough kept samples runs the bit-serial
// divider that forms both averages in parallel, then loads the output register.
// The output register holds a report until it is taken while the back end
// already works on the next commands; there is no clearing pass after reset.
module resistive_touch_sample_filter #(
  parameter int unsigned Samples    = rtsf_pkg::SAMPLES_DEFAULT,
  parameter int unsigned QueueDepth = rtsf_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  rtsf_req_if.sink                          req_i,
  rtsf_rsp_if.source                        rsp_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rtsf_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [rtsf_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [rtsf_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);

  rtsf_pkg::cfg_t cfg;
  rtsf_pkg::cmd_t push_cmd;
  rtsf_pkg::cmd_t pop_cmd;
  logic           push_valid;
  logic           push_ready;
  logic           pop_valid;
  logic           pop_ready;

  // Configuration registers.
  rtsf_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Classification of incoming reading pairs.
  rtsf_front u_front (
    .req_i       (req_i),
    .cmd_o       (push_cmd),
    .cmd_valid_o (push_valid),
    .cmd_ready_i (push_ready)
  );

  // Command queue between front and back.
  rtsf_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_cmd)
  );

  // Measurement execution and result register.
  rtsf_back #(
    .Samples (Samples)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_valid_i (pop_valid),
    .cmd_ready_o (pop_ready),
    .cmd_i       (pop_cmd),
    .rsp_o       (rsp_o)
  );

endmodule

>>> design/rtsf_regs.sv
// ----------------------------------------------------------------------------
// Resistive touch sample filter configuration registers
// APB-style register file holding the pressure threshold, the scaling enable
// and the screen dimensions. Writes complete in the access cycle.
// ----------------------------------------------------------------------------
module rtsf_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rtsf_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [rtsf_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [rtsf_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready,
  output rtsf_pkg::cfg_t                    cfg_o
);

  rtsf_pkg::cfg_t     cfg_q;
  rtsf_pkg::reg_idx_e reg_idx;
  logic               wr_en;

  assign pready  = 1'b1;
  assign reg_idx = rtsf_pkg::reg_idx_e'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite && pready;
  assign cfg_o   = cfg_q;

  // Register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pressure_threshold <= rtsf_pkg::THRESHOLD_RESET;
      cfg_q.convert_enable     <= rtsf_pkg::CONVERT_RESET;
      cfg_q.screen_width       <= rtsf_pkg::SCREEN_WIDTH_RESET;
      cfg_q.screen_height      <= rtsf_pkg::SCREEN_HEIGHT_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        rtsf_pkg::REG_THRESHOLD: begin
          cfg_q.pressure_threshold <= pwdata[rtsf_pkg::PRESSURE_W-1:0];
        end
        rtsf_pkg::REG_CONVERT: begin
          cfg_q.convert_enable <= pwdata[0];
        end
        rtsf_pkg::REG_SCREEN_WIDTH: begin
          cfg_q.screen_width <= pwdata[rtsf_pkg::COORD_W-1:0];
        end
        rtsf_pkg::REG_SCREEN_HEIGHT: begin
          cfg_q.screen_height <= pwdata[rtsf_pkg::COORD_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Read mux.
  always_comb begin
    case (reg_idx)
      rtsf_pkg::REG_THRESHOLD: begin
        prdata = rtsf_pkg::APB_DATA_W'(cfg_q.pressure_threshold);
      end
      rtsf_pkg::REG_CONVERT: begin
        prdata = rtsf_pkg::APB_DATA_W'(cfg_q.convert_enable);
      end
      rtsf_pkg::REG_SCREEN_WIDTH: begin
        prdata = rtsf_pkg::APB_DATA_W'(cfg_q.screen_width);
      end
      rtsf_pkg::REG_SCREEN_HEIGHT: begin
        prdata = rtsf_pkg::APB_DATA_W'(cfg_q.screen_height);
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

endmodule

>>> design/rtsf_front.sv
// ----------------------------------------------------------------------------
// Resistive touch sample filter front end
// Accepts reading pairs and classifies them: a pressure pair becomes a
// pressure value, a position pair becomes panel coordinates with an edge
// window flag. The classified command is pushed into the command queue.
// ----------------------------------------------------------------------------
module rtsf_front (
  rtsf_req_if.sink          req_i,
  output rtsf_pkg::cmd_t    cmd_o,
  output logic              cmd_valid_o,
  input  logic              cmd_ready_i
);

  logic [rtsf_pkg::VALUE_W-1:0] first_ext;
  logic [rtsf_pkg::VALUE_W-1:0] second_ext;
  logic [rtsf_pkg::VALUE_W-1:0] coord_x;
  logic [rtsf_pkg::VALUE_W-1:0] coord_y;
  logic                         x_ok;
  logic                         y_ok;

  // A transaction is taken whenever the queue has room.
  assign req_i.ready = cmd_ready_i;
  assign cmd_valid_o = req_i.valid;

  assign first_ext  = rtsf_pkg::VALUE_W'(req_i.first_reading);
  assign second_ext = rtsf_pkg::VALUE_W'(req_i.second_reading);

  // Panel coordinates are the span minus the reading.
  assign coord_x = rtsf_pkg::ADC_SPAN - first_ext;
  assign coord_y = rtsf_pkg::ADC_SPAN - second_ext;

  // Both coordinates must lie inside the edge window.
  assign x_ok = (coord_x >= rtsf_pkg::EDGE_LOW) && (coord_x <= rtsf_pkg::EDGE_HIGH);
  assign y_ok = (coord_y >= rtsf_pkg::EDGE_LOW) && (coord_y <= rtsf_pkg::EDGE_HIGH);

  // Build the command; pressure is span plus X- minus Y+.
  always_comb begin
    cmd_o.is_position = req_i.req_type;
    cmd_o.in_window   = x_ok && y_ok;
    cmd_o.pressure    = rtsf_pkg::ADC_SPAN + first_ext - second_ext;
    cmd_o.pos_x       = coord_x;
    cmd_o.pos_y       = coord_y;
  end

endmodule

>>> design/rtsf_fifo.sv
// ----------------------------------------------------------------------------
// Resistive touch sample filter command queue
// Small register queue that decouples the front end from the back end so
// each side can stall without holding up the other.
// ----------------------------------------------------------------------------
module rtsf_fifo #(
  parameter int unsigned Depth = rtsf_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  rtsf_pkg::cmd_t    push_data_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output rtsf_pkg::cmd_t    pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  rtsf_pkg::cmd_t  entries_q [Depth];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            push;
  logic            pop;

  assign push_ready_o = (count_q != FullCnt);
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = entries_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

>>> design/rtsf_back.sv
// ----------------------------------------------------------------------------
// Resistive touch sample filter back end
// Executes classified commands: pressure check, sample accumulation with
// optional screen scaling, a serial divider for the averages, and the
// output register for the result channel.
// ----------------------------------------------------------------------------
module rtsf_back #(
  parameter int unsigned Samples = rtsf_pkg::SAMPLES_DEFAULT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rtsf_pkg::cfg_t    cfg_i,
  input  logic              cmd_valid_i,
  output logic              cmd_ready_o,
  input  rtsf_pkg::cmd_t    cmd_i,
  rtsf_rsp_if.source        rsp_o
);

  localparam int unsigned SumW  = rtsf_pkg::SUM_W;
  localparam int unsigned CntW  = rtsf_pkg::COUNT_W;
  localparam int unsigned RemW  = rtsf_pkg::REM_W;
  localparam int unsigned ProdW = rtsf_pkg::PROD_W;
  localparam int unsigned CrdW  = rtsf_pkg::COORD_W;
  localparam logic [CntW-1:0] SamplesCnt = CntW'(Samples);
  localparam logic [CntW-1:0] MinKept    = CntW'((Samples > 1) ? (Samples / 2) : 1);
  localparam logic [CntW-1:0] DivLast    = CntW'(SumW - 1);

  typedef enum logic [2:0] {
    S_FETCH,
    S_MUL,
    S_ACC,
    S_DIV,
    S_EMIT
  } state_e;

  state_e                         state_q;
  rtsf_pkg::cmd_t                 cmd_q;
  logic                           collecting_q;
  logic [CntW-1:0]                seen_q;
  logic [CntW-1:0]                kept_q;
  logic [SumW-1:0]                sum_x_q;
  logic [SumW-1:0]                sum_y_q;
  logic [rtsf_pkg::PRESSURE_W-1:0] held_q;
  logic [ProdW-1:0]               prod_x_q;
  logic [ProdW-1:0]               prod_y_q;
  logic [SumW-1:0]                dq_x_q;
  logic [SumW-1:0]                dq_y_q;
  logic [RemW-1:0]                rem_x_q;
  logic [RemW-1:0]                rem_y_q;
  logic [CntW-1:0]                div_cnt_q;
  logic                           res_touched_q;
  logic                           out_valid_q;
  logic                           out_touched_q;
  logic [CrdW-1:0]                out_x_q;
  logic [CrdW-1:0]                out_y_q;
  logic [rtsf_pkg::PRESSURE_W-1:0] out_pressure_q;

  logic [SumW-1:0] add_x;
  logic [SumW-1:0] add_y;
  logic [SumW-1:0] sum_x_acc;
  logic [SumW-1:0] sum_y_acc;
  logic [CntW-1:0] kept_acc;
  logic [CntW-1:0] seen_next;
  logic [RemW:0]   rem_x_sh;
  logic [RemW:0]   rem_y_sh;
  logic            q_x;
  logic            q_y;
  logic [RemW:0]   rem_x_sub;
  logic [RemW:0]   rem_y_sub;
  logic            out_free;

  assign cmd_ready_o     = (state_q == S_FETCH);
  assign out_free        = !out_valid_q || rsp_o.ready;
  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.touched   = out_touched_q;
  assign rsp_o.pos_x     = out_x_q;
  assign rsp_o.pos_y     = out_y_q;
  assign rsp_o.pressure  = out_pressure_q;

  // Sample accumulation: raw coordinates or the scaled product over 4096.
  always_comb begin
    if (cfg_i.convert_enable) begin
      add_x = SumW'(prod_x_q[ProdW-2:12]);
      add_y = SumW'(prod_y_q[ProdW-2:12]);
    end else begin
      add_x = SumW'(cmd_q.pos_x);
      add_y = SumW'(cmd_q.pos_y);
    end
    if (cmd_q.in_window) begin
      sum_x_acc = sum_x_q + add_x;
      sum_y_acc = sum_y_q + add_y;
      kept_acc  = kept_q + 1'b1;
    end else begin
      sum_x_acc = sum_x_q;
      sum_y_acc = sum_y_q;
      kept_acc  = kept_q;
    end
    seen_next = seen_q + 1'b1;
  end

  // One restoring division step for each axis.
  always_comb begin
    rem_x_sh  = {rem_x_q, dq_x_q[SumW-1]};
    rem_y_sh  = {rem_y_q, dq_y_q[SumW-1]};
    q_x       = (rem_x_sh >= (RemW+1)'(kept_q));
    q_y       = (rem_y_sh >= (RemW+1)'(kept_q));
    rem_x_sub = q_x ? (rem_x_sh - (RemW+1)'(kept_q)) : rem_x_sh;
    rem_y_sub = q_y ? (rem_y_sh - (RemW+1)'(kept_q)) : rem_y_sh;
  end

  // Command sequencer and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_FETCH;
      cmd_q          <= '0;
      collecting_q   <= 1'b0;
      seen_q         <= '0;
      kept_q         <= '0;
      sum_x_q        <= '0;
      sum_y_q        <= '0;
      held_q         <= '0;
      prod_x_q       <= '0;
      prod_y_q       <= '0;
      dq_x_q         <= '0;
      dq_y_q         <= '0;
      rem_x_q        <= '0;
      rem_y_q        <= '0;
      div_cnt_q      <= '0;
      res_touched_q  <= 1'b0;
      out_valid_q    <= 1'b0;
      out_touched_q  <= 1'b0;
      out_x_q        <= '0;
      out_y_q        <= '0;
      out_pressure_q <= '0;
    end else begin
      // The output register is loaded by a report or emptied when taken.
      if ((state_q == S_EMIT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_FETCH: begin
          if (cmd_valid_i) begin
            cmd_q <= cmd_i;
            if (!cmd_i.is_position) begin
              // A pressure pair always starts a fresh measurement.
              seen_q       <= '0;
              kept_q       <= '0;
              sum_x_q      <= '0;
              sum_y_q      <= '0;
              held_q       <= cmd_i.pressure;
              if (cmd_i.pressure < cfg_i.pressure_threshold) begin
                collecting_q  <= 1'b0;
                res_touched_q <= 1'b0;
                state_q       <= S_EMIT;
              end else begin
                collecting_q <= 1'b1;
              end
            end else if (collecting_q) begin
              state_q <= S_MUL;
            end
          end
        end
        S_MUL: begin
          prod_x_q <= cmd_q.pos_x * cfg_i.screen_width;
          prod_y_q <= cmd_q.pos_y * cfg_i.screen_height;
          state_q  <= S_ACC;
        end
        S_ACC: begin
          sum_x_q <= sum_x_acc;
          sum_y_q <= sum_y_acc;
          kept_q  <= kept_acc;
          seen_q  <= seen_next;
          if (seen_next == SamplesCnt) begin
            if (kept_acc >= MinKept) begin
              dq_x_q    <= sum_x_acc;
              dq_y_q    <= sum_y_acc;
              rem_x_q   <= '0;
              rem_y_q   <= '0;
              div_cnt_q <= '0;
              state_q   <= S_DIV;
            end else begin
              res_touched_q <= 1'b0;
              state_q       <= S_EMIT;
            end
          end else begin
            state_q <= S_FETCH;
          end
        end
        S_DIV: begin
          dq_x_q    <= {dq_x_q[SumW-2:0], q_x};
          dq_y_q    <= {dq_y_q[SumW-2:0], q_y};
          rem_x_q   <= rem_x_sub[RemW-1:0];
          rem_y_q   <= rem_y_sub[RemW-1:0];
          div_cnt_q <= div_cnt_q + 1'b1;
          if (div_cnt_q == DivLast) begin
            res_touched_q <= 1'b1;
            state_q       <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            // A report ends the measurement; a miss reports all zeros.
            out_touched_q  <= res_touched_q;
            out_x_q        <= res_touched_q ? dq_x_q[CrdW-1:0] : '0;
            out_y_q        <= res_touched_q ? dq_y_q[CrdW-1:0] : '0;
            out_pressure_q <= res_touched_q ? held_q : '0;
            collecting_q   <= 1'b0;
            seen_q         <= '0;
            kept_q         <= '0;
            sum_x_q        <= '0;
            sum_y_q        <= '0;
            state_q        <= S_FETCH;
          end
        end
        default: begin
          state_q <= S_FETCH;
        end
      endcase
    end
  end

endmodule

>>> tb/tb_resistive_touch_sample_filter.sv
// ----------------------------------------------------------------------------
// Resistive touch sample filter testbench
// Drives ADC reading pairs through the request channel and checks every touch
// report against a cycle-free prediction of pressure check, edge rejection,
// screen scaling and averaging. Starts with directed corner cases, then runs
// random measurements under several register settings. Both channels see
// random gaps and stalls, and one long result stall backs up the input.
// ----------------------------------------------------------------------------
module tb_resistive_touch_sample_filter;
  timeunit 1ns;
  timeprecision 1ps;

  import rtsf_pkg::*;

  localparam int unsigned SAMPLES      = SAMPLES_DEFAULT;
  localparam int unsigned MIN_KEPT     = (SAMPLES / 2 == 0) ? 1 : SAMPLES / 2;
  localparam int unsigned CLK_PERIOD   = 10;
  localparam int unsigned RANDOM_ITEMS = 750;
  localparam int unsigned SETTLE       = 120;
  localparam int unsigned LONG_HOLD    = 400;
  localparam int unsigned STALL_LIMIT  = 5000;

  typedef enum logic {
    REQ_PRESSURE = 1'b0,
    REQ_POSITION = 1'b1
  } req_kind_e;

  typedef struct {
    req_kind_e              kind;
    logic [READING_W-1:0]   first;
    logic [READING_W-1:0]   second;
  } adc_pair_t;

  typedef struct {
    logic                  touched;
    logic [COORD_W-1:0]    pos_x;
    logic [COORD_W-1:0]    pos_y;
    logic [PRESSURE_W-1:0] pressure;
  } touch_report_t;

  // Clock, reset and configuration port.
  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  rtsf_req_if req_if ();
  rtsf_rsp_if rsp_if ();

  resistive_touch_sample_filter #(
    .Samples (SAMPLES)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .rsp_o   (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Predicted filter state and register copy.
  cfg_t                  filter_cfg;
  logic                  collecting;
  logic [COUNT_W-1:0]    pairs_seen;
  logic [COUNT_W-1:0]    pairs_kept;
  logic [SUM_W-1:0]      sum_x;
  logic [SUM_W-1:0]      sum_y;
  logic [PRESSURE_W-1:0] held_pressure;

  adc_pair_t     pending_pairs[$];
  touch_report_t touch_reports_q[$];

  // Shared between the stimulus, the driver and the monitor.
  bit          drv_gaps_on;
  bit          mon_stalls_on;
  bit          offering;
  int unsigned holds_requested;
  int unsigned random_queued;
  int unsigned mismatch_cnt;
  int unsigned idle_cycles;

  // Gap length: mostly none, often short, rarely long.
  function automatic int unsigned pick_delay();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic void clear_collection();
    collecting    = 1'b0;
    pairs_seen    = '0;
    pairs_kept    = '0;
    sum_x         = '0;
    sum_y         = '0;
    held_pressure = '0;
  endfunction

  function automatic logic [15:0] scale_coord(logic [VALUE_W-1:0] v, logic [COORD_W-1:0] span);
    logic [31:0] prod;
    prod = 32'(v) * 32'(span);
    return 16'(prod >> 12);
  endfunction

  // Advances the predicted filter by one accepted pair and records any report.
  function automatic void predict_pair(adc_pair_t p);
    logic [PRESSURE_W-1:0] z;
    logic [VALUE_W-1:0]    vx;
    logic [VALUE_W-1:0]    vy;
    logic [15:0]           add_x;
    logic [15:0]           add_y;
    touch_report_t         rep;
    rep = '{touched: 1'b0, pos_x: '0, pos_y: '0, pressure: '0};
    if (p.kind == REQ_PRESSURE) begin
      z = PRESSURE_W'(ADC_SPAN + VALUE_W'(p.first) - VALUE_W'(p.second));
      clear_collection();
      if (z < filter_cfg.pressure_threshold) begin
        touch_reports_q.push_back(rep);
      end else begin
        collecting    = 1'b1;
        held_pressure = z;
      end
    end else if (collecting) begin
      vx = ADC_SPAN - VALUE_W'(p.first);
      vy = ADC_SPAN - VALUE_W'(p.second);
      if (vx >= EDGE_LOW && vx <= EDGE_HIGH && vy >= EDGE_LOW && vy <= EDGE_HIGH) begin
        if (filter_cfg.convert_enable) begin
          add_x = scale_coord(vx, filter_cfg.screen_width);
          add_y = scale_coord(vy, filter_cfg.screen_height);
        end else begin
          add_x = 16'(vx);
          add_y = 16'(vy);
        end
        sum_x      = SUM_W'(sum_x + add_x);
        sum_y      = SUM_W'(sum_y + add_y);
        pairs_kept = pairs_kept + 1'b1;
      end
      pairs_seen = pairs_seen + 1'b1;
      if (pairs_seen >= SAMPLES) begin
        if (pairs_kept >= MIN_KEPT) begin
          rep.touched  = 1'b1;
          rep.pos_x    = 16'(sum_x / pairs_kept);
          rep.pos_y    = 16'(sum_y / pairs_kept);
          rep.pressure = held_pressure;
        end
        clear_collection();
        touch_reports_q.push_back(rep);
      end
    end
  endfunction

  // Request driver: offers queued pairs with optional gaps between them.
  adc_pair_t   cur_pair;
  int unsigned gap_left;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid          <= 1'b0;
      req_if.req_type       <= 1'b0;
      req_if.first_reading  <= '0;
      req_if.second_reading <= '0;
      offering = 1'b0;
      gap_left = 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        predict_pair(cur_pair);
        offering = 1'b0;
        gap_left = drv_gaps_on ? pick_delay() : 0;
      end
      if (!offering) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_pairs.size() > 0) begin
          cur_pair = pending_pairs.pop_front();
          offering = 1'b1;
          req_if.req_type       <= cur_pair.kind;
          req_if.first_reading  <= cur_pair.first;
          req_if.second_reading <= cur_pair.second;
        end
      end
      req_if.valid <= offering;
    end
  end

  // Result monitor: checks each report and stalls the result channel.
  int unsigned   stall_left;
  int unsigned   holds_taken;
  touch_report_t want;
  logic          take_ready;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      stall_left  = 0;
      holds_taken = 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (touch_reports_q.size() == 0) begin
          $error("touch report with none expected: touched %0d x %0d y %0d pressure %0d",
                 rsp_if.touched, rsp_if.pos_x, rsp_if.pos_y, rsp_if.pressure);
          mismatch_cnt++;
        end else begin
          want = touch_reports_q.pop_front();
          if (rsp_if.touched !== want.touched) begin
            $error("touched: expected %0d, actual %0d", want.touched, rsp_if.touched);
            mismatch_cnt++;
          end
          if (rsp_if.pos_x !== want.pos_x) begin
            $error("pos_x: expected %0d, actual %0d", want.pos_x, rsp_if.pos_x);
            mismatch_cnt++;
          end
          if (rsp_if.pos_y !== want.pos_y) begin
            $error("pos_y: expected %0d, actual %0d", want.pos_y, rsp_if.pos_y);
            mismatch_cnt++;
          end
          if (rsp_if.pressure !== want.pressure) begin
            $error("pressure: expected %0d, actual %0d", want.pressure, rsp_if.pressure);
            mismatch_cnt++;
          end
        end
      end
      if (holds_taken != holds_requested) begin
        holds_taken = holds_requested;
        stall_left  = LONG_HOLD;
      end
      if (stall_left > 0) begin
        stall_left--;
        take_ready = 1'b0;
      end else begin
        take_ready = 1'b1;
        if (mon_stalls_on && $urandom_range(3) == 0) stall_left = pick_delay();
      end
      rsp_if.ready <= take_ready;
    end
  end

  // Watchdog: ends the run when no transaction moves for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || psel) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // Register write over the configuration port; the copy follows the write.
  task automatic write_register(reg_idx_e idx, logic [APB_DATA_W-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_THRESHOLD:     filter_cfg.pressure_threshold = value[PRESSURE_W-1:0];
      REG_CONVERT:       filter_cfg.convert_enable     = value[0];
      REG_SCREEN_WIDTH:  filter_cfg.screen_width       = value[COORD_W-1:0];
      REG_SCREEN_HEIGHT: filter_cfg.screen_height      = value[COORD_W-1:0];
      default: ;
    endcase
  endtask

  task automatic write_all(int unsigned thr, bit conv, int unsigned wid, int unsigned hgt);
    write_register(REG_THRESHOLD, thr);
    write_register(REG_CONVERT, APB_DATA_W'(conv));
    write_register(REG_SCREEN_WIDTH, wid);
    write_register(REG_SCREEN_HEIGHT, hgt);
  endtask

  // Waits until every pair is sent and every report is in, then lets the
  // back end finish any position pairs still in flight.
  task automatic wait_idle();
    while (pending_pairs.size() != 0 || offering || touch_reports_q.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic push_pair(req_kind_e kind, int unsigned first, int unsigned second);
    adc_pair_t p;
    p.kind   = kind;
    p.first  = READING_W'(first);
    p.second = READING_W'(second);
    pending_pairs.push_back(p);
    random_queued++;
  endtask

  // Pressure pair with readings chosen so that 4096 + first - second equals z.
  task automatic push_pressure(int z);
    int d;
    int r1;
    int r2;
    d = z - 4096;
    if (d >= 0) begin
      r1 = $urandom_range(4095, d);
      r2 = r1 - d;
    end else begin
      r2 = $urandom_range(4095, -d);
      r1 = r2 + d;
    end
    push_pair(REQ_PRESSURE, r1, r2);
  endtask

  task automatic push_touch_pressure();
    int unsigned lo;
    lo = (filter_cfg.pressure_threshold == 0) ? 1 : filter_cfg.pressure_threshold;
    push_pressure($urandom_range(8191, lo));
  endtask

  task automatic push_light_pressure();
    if (filter_cfg.pressure_threshold <= 1) begin
      push_touch_pressure();
    end else begin
      push_pressure($urandom_range(filter_cfg.pressure_threshold - 1, 1));
    end
  endtask

  function automatic int unsigned edge_reading();
    return $urandom_range(1) ? $urandom_range(49, 0) : $urandom_range(4095, 4047);
  endfunction

  task automatic push_position(int unsigned keep_pct);
    int unsigned r;
    r = $urandom_range(99);
    if (r < keep_pct) begin
      push_pair(REQ_POSITION, $urandom_range(4046, 50), $urandom_range(4046, 50));
    end else if (r % 3 == 0) begin
      push_pair(REQ_POSITION, edge_reading(), $urandom_range(4095, 0));
    end else if (r % 3 == 1) begin
      push_pair(REQ_POSITION, $urandom_range(4095, 0), edge_reading());
    end else begin
      push_pair(REQ_POSITION, $urandom_range(4095, 0), $urandom_range(4095, 0));
    end
  endtask

  // Mix of full measurements, light touches, abandoned ones and noise.
  task automatic queue_random_batch(int unsigned n_items);
    int unsigned stop_at;
    int unsigned sel;
    int unsigned keep_pct;
    int unsigned n_pos;
    stop_at = random_queued + n_items;
    while (random_queued < stop_at) begin
      sel = $urandom_range(99);
      if (sel < 70) begin
        case ($urandom_range(3))
          0:       keep_pct = 30;
          1:       keep_pct = 60;
          default: keep_pct = 92;
        endcase
        push_touch_pressure();
        repeat (SAMPLES) push_position(keep_pct);
      end else if (sel < 80) begin
        push_light_pressure();
      end else if (sel < 90) begin
        n_pos = $urandom_range(SAMPLES - 1, 0);
        push_touch_pressure();
        repeat (n_pos) push_position(80);
      end else begin
        repeat ($urandom_range(3, 1))
          push_pair(req_kind_e'($urandom_range(1)), $urandom_range(4095, 0),
                    $urandom_range(4095, 0));
      end
    end
  endtask

  // Stimulus sequence.
  int unsigned phase;

  initial begin
    rst_ni          = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    drv_gaps_on     = 1'b0;
    mon_stalls_on   = 1'b0;
    holds_requested = 0;
    random_queued   = 0;
    mismatch_cnt    = 0;
    idle_cycles     = 0;
    filter_cfg.pressure_threshold = THRESHOLD_RESET;
    filter_cfg.convert_enable     = CONVERT_RESET;
    filter_cfg.screen_width       = SCREEN_WIDTH_RESET;
    filter_cfg.screen_height      = SCREEN_HEIGHT_RESET;
    clear_collection();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: lightest pressure reports no touch at once.
    push_pair(REQ_PRESSURE, 0, 4095);
    // Heaviest pressure, then readings on and just past both window edges.
    push_pair(REQ_PRESSURE, 4095, 0);
    push_pair(REQ_POSITION, 50, 4046);
    push_pair(REQ_POSITION, 4046, 50);
    push_pair(REQ_POSITION, 49, 2000);
    push_pair(REQ_POSITION, 2000, 4047);
    push_pair(REQ_POSITION, 0, 4095);
    push_pair(REQ_POSITION, 4095, 0);
    push_pair(REQ_POSITION, 1000, 3000);
    push_pair(REQ_POSITION, 2048, 2048);
    // A position pair with no measurement running is dropped.
    push_pair(REQ_POSITION, 1234, 2345);
    // Pressure exactly at threshold, then a new pressure abandons it.
    push_pair(REQ_PRESSURE, 0, 2096);
    push_pair(REQ_POSITION, 500, 600);
    push_pair(REQ_POSITION, 700, 800);
    push_pair(REQ_POSITION, 900, 1000);
    push_pair(REQ_PRESSURE, 0, 2097);
    // Too few pairs inside the window gives no touch.
    push_pair(REQ_PRESSURE, 2048, 2048);
    push_pair(REQ_POSITION, 100, 200);
    push_pair(REQ_POSITION, 10, 200);
    push_pair(REQ_POSITION, 300, 4080);
    push_pair(REQ_POSITION, 3000, 3100);
    push_pair(REQ_POSITION, 4090, 20);
    push_pair(REQ_POSITION, 3500, 4095);
    push_pair(REQ_POSITION, 3900, 3950);
    push_pair(REQ_POSITION, 0, 0);
    wait_idle();
    random_queued = 0;

    // Random phases, each under its own register setting.
    for (phase = 0; random_queued < RANDOM_ITEMS; phase++) begin
      case (phase)
        0:       write_all(0, 1'b1, 65535, 65535);
        1:       write_all(8191, 1'b0, 320, 240);
        2:       write_all(4096, 1'b1, 1, 1);
        3:       write_all($urandom_range(3000, 500), 1'b1, 0, 0);
        default: write_all($urandom_range(6000, 0), 1'($urandom_range(1)),
                           $urandom_range(65535, 1), $urandom_range(65535, 1));
      endcase
      drv_gaps_on   = (phase % 3 != 0);
      mon_stalls_on = (phase % 4 != 1);

      if (phase == 2) begin
        // Long result stall while light touches keep coming.
        holds_requested++;
        repeat (30) push_light_pressure();
        wait_idle();
      end
      if (phase == 3) begin
        // Screen size changes part way through a measurement.
        push_touch_pressure();
        repeat (3) push_position(100);
        wait_idle();
        write_register(REG_SCREEN_WIDTH, 800);
        write_register(REG_SCREEN_HEIGHT, 480);
        repeat (SAMPLES - 3) push_position(100);
        wait_idle();
      end

      queue_random_batch(100);
      wait_idle();
    end

    if (mismatch_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/rtsf_pkg.sv
design/rtsf_if.sv
design/rtsf_regs.sv
design/rtsf_front.sv
design/rtsf_fifo.sv
design/rtsf_back.sv
design/resistive_touch_sample_filter.sv
tb/tb_resistive_touch_sample_filter.sv
